// ----- rtl/assert_macros.svh -----
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, cond, prop)
`define ASSERT_NEXT(label, cond, prop)
`endif

`endif

// ----- rtl/smd_pkg.sv -----
`timescale 1ns / 1ps

package smd_pkg;

  localparam int UPC_W = 4;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_INIT,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV,
    OP_RES,
    OP_SAT,
    OP_ZERO,
    OP_DZ,
    OP_EMIT
  } dp_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_NO_IN,
    JC_DZ,
    JC_ZF,
    JC_CNT_NZ,
    JC_HI_GE,
    JC_OUT_BUSY
  } jmp_cond_t;

  typedef struct packed {
    dp_op_t           op;
    jmp_cond_t        cond;
    logic [UPC_W-1:0] target;
    logic             last;    // fall through to the wait step
  } ctrl_word_t;

  // microcode addresses
  localparam logic [UPC_W-1:0] UA_WAIT     = 4'd0;
  localparam logic [UPC_W-1:0] UA_CHECK_DZ = 4'd1;
  localparam logic [UPC_W-1:0] UA_CHECK_ZF = 4'd2;
  localparam logic [UPC_W-1:0] UA_MUL      = 4'd3;
  localparam logic [UPC_W-1:0] UA_DIV_INIT = 4'd4;
  localparam logic [UPC_W-1:0] UA_DIV      = 4'd5;
  localparam logic [UPC_W-1:0] UA_RES      = 4'd6;
  localparam logic [UPC_W-1:0] UA_SAT      = 4'd7;
  localparam logic [UPC_W-1:0] UA_ZERO     = 4'd8;
  localparam logic [UPC_W-1:0] UA_DZ       = 4'd9;
  localparam logic [UPC_W-1:0] UA_EMIT     = 4'd10;

  function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] addr);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: JC_ALWAYS, target: UA_WAIT, last: 1'b0};
    unique case (addr)
      UA_WAIT:     w = '{op: OP_LOAD,     cond: JC_NO_IN,    target: UA_WAIT,  last: 1'b0};
      UA_CHECK_DZ: w = '{op: OP_NOP,      cond: JC_DZ,       target: UA_DZ,    last: 1'b0};
      UA_CHECK_ZF: w = '{op: OP_MUL_INIT, cond: JC_ZF,       target: UA_ZERO,  last: 1'b0};
      UA_MUL:      w = '{op: OP_MUL,      cond: JC_CNT_NZ,   target: UA_MUL,   last: 1'b0};
      UA_DIV_INIT: w = '{op: OP_DIV_INIT, cond: JC_HI_GE,    target: UA_SAT,   last: 1'b0};
      UA_DIV:      w = '{op: OP_DIV,      cond: JC_CNT_NZ,   target: UA_DIV,   last: 1'b0};
      UA_RES:      w = '{op: OP_RES,      cond: JC_ALWAYS,   target: UA_EMIT,  last: 1'b0};
      UA_SAT:      w = '{op: OP_SAT,      cond: JC_ALWAYS,   target: UA_EMIT,  last: 1'b0};
      UA_ZERO:     w = '{op: OP_ZERO,     cond: JC_ALWAYS,   target: UA_EMIT,  last: 1'b0};
      UA_DZ:       w = '{op: OP_DZ,       cond: JC_NONE,     target: UA_EMIT,  last: 1'b0};
      UA_EMIT:     w = '{op: OP_EMIT,     cond: JC_OUT_BUSY, target: UA_EMIT,  last: 1'b1};
      default:     w = '{op: OP_NOP,      cond: JC_ALWAYS,   target: UA_WAIT,  last: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/signed_multiply_then_divide_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// signed multiply-then-divide: quotient = factor_a * factor_b / divisor_in
// input channel: in_valid / in_stall with in_factor_a, in_factor_b, in_divisor_in;
//   a transaction is taken when in_valid is high and in_stall is low
// result channel: out_valid / out_stall with out_quotient, out_overflow,
//   out_divide_by_zero; one result transaction per input transaction
// a microcoded sequencer steps one shared datapath: magnitude load, a
//   DATA_WIDTH step shift-and-add multiply, an overflow check on the product
//   high half, a DATA_WIDTH step restoring divide, then sign and saturation
// a full item runs the multiply loop, the high half check and the divide loop;
//   an item whose product high half already rules out a fitting quotient goes
//   from that check straight to saturation, and a zero divisor or a zero factor
//   skips both loops; the next transaction is taken only once the sequencer is
//   back on its wait step after the result goes into the output register, so no
//   new item is taken while one is in flight and the two iteration loops set the rate
// in_stall is high whenever the sequencer is away from its wait step
// the output register holds one result; while out_stall keeps it, the
//   sequencer parks on its emit step and takes no new input
// reset (rst_n low, synchronous) returns the sequencer to the wait step and
//   empties the output register; no clearing pass is needed
module signed_multiply_then_divide_core
  import smd_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_factor_a,
  input  logic signed [DATA_WIDTH-1:0] in_factor_b,
  input  logic signed [DATA_WIDTH-1:0] in_divisor_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_quotient,
  output logic                         out_overflow,
  output logic                         out_divide_by_zero
);

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0]      CNT_INIT = CNT_W'(DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] LIMIT    = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] ONE      = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

  // magnitude of a two's complement word; the most negative code maps to 2^(W-1)
  function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? (~v + ONE) : v;
  endfunction

  // sequencer
  logic [UPC_W-1:0] upc_r, upc_nxt;
  ctrl_word_t       cw;
  logic             take_jump;

  // datapath registers
  logic [DATA_WIDTH-1:0] mag_a_r, mag_a_nxt;
  logic [DATA_WIDTH-1:0] mag_b_r, mag_b_nxt;
  logic [DATA_WIDTH-1:0] mag_d_r, mag_d_nxt;
  logic                  neg_r, neg_nxt;
  logic [DATA_WIDTH-1:0] hi_r, hi_nxt;     // product high half, then remainder
  logic [DATA_WIDTH-1:0] lo_r, lo_nxt;     // multiplier, product low half, quotient
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] res_mag_r, res_mag_nxt;
  logic                  res_ovf_r, res_ovf_nxt;
  logic                  res_dz_r, res_dz_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_q_r, out_q_nxt;
  logic                  out_ovf_r, out_ovf_nxt;
  logic                  out_dz_r, out_dz_nxt;

  logic                  in_fire;
  logic                  out_free;
  logic [DATA_WIDTH:0]   mul_sum;
  logic [DATA_WIDTH:0]   div_trial;
  logic [DATA_WIDTH:0]   div_diff;
  logic                  div_ge;

  assign cw       = ucode_rom(upc_r);
  assign in_stall = (upc_r != UA_WAIT);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // one shift-and-add step and one restoring divide step
  assign mul_sum   = {1'b0, hi_r} + {1'b0, (lo_r[0] ? mag_a_r : {DATA_WIDTH{1'b0}})};
  assign div_trial = {hi_r, lo_r[DATA_WIDTH-1]};
  assign div_diff  = div_trial - {1'b0, mag_d_r};
  assign div_ge    = (div_trial >= {1'b0, mag_d_r});

  // jump decision
  always_comb begin
    unique case (cw.cond)
      JC_NONE:     take_jump = 1'b0;
      JC_ALWAYS:   take_jump = 1'b1;
      JC_NO_IN:    take_jump = !in_fire;
      JC_DZ:       take_jump = (mag_d_r == '0);
      JC_ZF:       take_jump = (mag_a_r == '0) || (mag_b_r == '0);
      JC_CNT_NZ:   take_jump = (cnt_r != '0);
      JC_HI_GE:    take_jump = (hi_r >= mag_d_r);   // quotient would not fit the word
      JC_OUT_BUSY: take_jump = !out_free;
      default:     take_jump = 1'b0;
    endcase
  end

  always_comb begin
    if (take_jump) begin
      upc_nxt = cw.target;
    end else if (cw.last) begin
      upc_nxt = UA_WAIT;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  // datapath, driven by the control word
  always_comb begin
    mag_a_nxt     = mag_a_r;
    mag_b_nxt     = mag_b_r;
    mag_d_nxt     = mag_d_r;
    neg_nxt       = neg_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    cnt_nxt       = cnt_r;
    res_mag_nxt   = res_mag_r;
    res_ovf_nxt   = res_ovf_r;
    res_dz_nxt    = res_dz_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_q_nxt     = out_q_r;
    out_ovf_nxt   = out_ovf_r;
    out_dz_nxt    = out_dz_r;
    unique case (cw.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        if (in_fire) begin
          mag_a_nxt = mag_of(in_factor_a);
          mag_b_nxt = mag_of(in_factor_b);
          mag_d_nxt = mag_of(in_divisor_in);
          neg_nxt   = in_factor_a[DATA_WIDTH-1] ^ in_factor_b[DATA_WIDTH-1]
                      ^ in_divisor_in[DATA_WIDTH-1];
        end
      end
      OP_MUL_INIT: begin
        hi_nxt  = '0;
        lo_nxt  = mag_b_r;
        cnt_nxt = CNT_INIT;
      end
      OP_MUL: begin
        hi_nxt  = mul_sum[DATA_WIDTH:1];
        lo_nxt  = {mul_sum[0], lo_r[DATA_WIDTH-1:1]};
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_DIV_INIT: begin
        cnt_nxt = CNT_INIT;
      end
      OP_DIV: begin
        hi_nxt  = div_ge ? div_diff[DATA_WIDTH-1:0] : div_trial[DATA_WIDTH-1:0];
        lo_nxt  = {lo_r[DATA_WIDTH-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_RES: begin
        // top bit set means the quotient is past the positive limit
        res_mag_nxt = lo_r[DATA_WIDTH-1] ? LIMIT : lo_r;
        res_ovf_nxt = lo_r[DATA_WIDTH-1];
        res_dz_nxt  = 1'b0;
      end
      OP_SAT: begin
        res_mag_nxt = LIMIT;
        res_ovf_nxt = 1'b1;
        res_dz_nxt  = 1'b0;
      end
      OP_ZERO: begin
        res_mag_nxt = '0;
        res_ovf_nxt = 1'b0;
        res_dz_nxt  = 1'b0;
      end
      OP_DZ: begin
        res_mag_nxt = '0;
        res_ovf_nxt = 1'b0;
        res_dz_nxt  = 1'b1;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_q_nxt     = neg_r ? (~res_mag_r + ONE) : res_mag_r;
          out_ovf_nxt   = res_ovf_r;
          out_dz_nxt    = res_dz_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UA_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    mag_a_r   <= mag_a_nxt;
    mag_b_r   <= mag_b_nxt;
    mag_d_r   <= mag_d_nxt;
    neg_r     <= neg_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    cnt_r     <= cnt_nxt;
    res_mag_r <= res_mag_nxt;
    res_ovf_r <= res_ovf_nxt;
    res_dz_r  <= res_dz_nxt;
    out_q_r   <= out_q_nxt;
    out_ovf_r <= out_ovf_nxt;
    out_dz_r  <= out_dz_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_quotient       = out_q_r;
  assign out_overflow       = out_ovf_r;
  assign out_divide_by_zero = out_dz_r;

  // an accepted transaction always goes to the divisor check next
  `ASSERT_NEXT(a_accept_to_check, in_fire, upc_r == UA_CHECK_DZ)
  // the remainder stays below the divisor through the divide loop
  `ASSERT_IMPLIES(a_rem_below_div, upc_r == UA_DIV, hi_r < mag_d_r)
  // a zero divisor result carries a zero quotient and no overflow
  `ASSERT_IMPLIES(a_dz_result, out_valid_r && out_dz_r, (out_q_r == '0) && !out_ovf_r)
  // a saturated result sits at one of the two limits
  `ASSERT_IMPLIES(a_sat_result, out_valid_r && out_ovf_r,
                  (out_q_r == LIMIT) || (out_q_r == (~LIMIT + ONE)))

endmodule
